// ----- rtl/core/i2c_master_bit_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// condition that holds at every clock edge out of reset
`define I2CMBS_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition that implies a consequence in the next cycle
`define I2CMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/i2cmbs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer package
// shared types, codes and constants of the bit sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmbs_pkg;

   // function codes of the request
   localparam logic [2:0] FUNC_START    = 3'd0;
   localparam logic [2:0] FUNC_STOP     = 3'd1;
   localparam logic [2:0] FUNC_WRITE    = 3'd2;
   localparam logic [2:0] FUNC_WAIT_ACK = 3'd3;
   localparam logic [2:0] FUNC_READ     = 3'd4;

   // register indexes of the csr channel
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_TICKS_PER_UNIT = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK_LIMIT      = 8'd1;

   // register reset values
   localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd1;
   localparam logic [7:0]  ACK_LIMIT_RESET      = 8'd250;

   // datapath widths and limits
   localparam int DELAY_W     = 19;
   localparam int BIT_COUNT_W = 4;
   localparam logic [BIT_COUNT_W-1:0] BITS_PER_BYTE = 4'd8;
   localparam logic [7:0] ACK_COUNT_MAX = 8'hFF;

   // delay lengths as shifts of one unit
   localparam logic [1:0] SHIFT_FOUR_UNITS = 2'd2;
   localparam logic [1:0] SHIFT_TWO_UNITS  = 2'd1;
   localparam logic [1:0] SHIFT_ONE_UNIT   = 2'd0;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // command class decided by the front
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_WAIT_ACK,
      CMD_READ
   } cmd_kind_type;

   // bus phase of the sequencer
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_A,
      PH_START_B,
      PH_STOP_A,
      PH_STOP_B,
      PH_STOP_C,
      PH_WR_A,
      PH_WR_B,
      PH_WR_C,
      PH_WA_A,
      PH_WA_B,
      PH_WA_POLL,
      PH_RD_A,
      PH_RD_B,
      PH_AK_A,
      PH_AK_B
   } phase_type;

   // one tick as held in the queue
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tx_byte;
      logic         send_ack;
      logic         sda_sampled;
   } tick_entry_type;

   // configuration seen by the back
   typedef struct packed {
      logic [15:0] ticks_per_unit;
      logic [7:0]  ack_limit;
   } cfg_type;

   // ticks of a delay: one unit shifted left by 0, 1 or 2
   function automatic logic [DELAY_W-1:0] delay_ticks(input logic [15:0] unit,
                                                      input logic [1:0]  shift);
      logic [DELAY_W-1:0] wide;
      wide = {{(DELAY_W-16){1'b0}}, unit};
      return wide << shift;
   endfunction

endpackage

// ----- rtl/core/i2cmbs_ifs.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer channel interfaces
// request, response and csr write channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// request channel: one tick per transfer
interface i2cmbs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] func;
   logic [7:0] tx_byte;
   logic       send_ack;
   logic       sda_sampled;

   modport source (output valid, cmd_valid, func, tx_byte, send_ack, sda_sampled,
                   input ready);
   modport sink (input valid, cmd_valid, func, tx_byte, send_ack, sda_sampled,
                 output ready);
endinterface

// response channel: line levels and status after each tick
interface i2cmbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_release;
   logic       sda_release;
   logic       busy_res;
   logic       cmd_done;
   logic [7:0] rx_byte;
   logic       nack_timeout;

   modport source (output valid, scl_release, sda_release, busy_res, cmd_done,
                   rx_byte, nack_timeout, input ready);
   modport sink (input valid, scl_release, sda_release, busy_res, cmd_done,
                 rx_byte, nack_timeout, output ready);
endinterface

// csr write channel
interface i2cmbs_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  addr;
   logic [15:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

// ----- rtl/core/i2cmbs_front.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer front
// accepts request ticks and classifies the offered command for the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmbs_front
   import i2cmbs_pkg::*;
(
   i2cmbs_req_if.sink      req_ch,
   input  logic            q_ready,
   output logic            push,
   output tick_entry_type  push_entry
);

   // transfer whenever the queue has room
   assign req_ch.ready = q_ready;
   assign push         = req_ch.valid && q_ready;

   // decode the command class, unknown codes carry no command
   always_comb begin
      push_entry.tx_byte     = req_ch.tx_byte;
      push_entry.send_ack    = req_ch.send_ack;
      push_entry.sda_sampled = req_ch.sda_sampled;
      push_entry.kind        = CMD_NONE;
      if (req_ch.cmd_valid) begin
         unique case (req_ch.func)
            FUNC_START:    push_entry.kind = CMD_START;
            FUNC_STOP:     push_entry.kind = CMD_STOP;
            FUNC_WRITE:    push_entry.kind = CMD_WRITE;
            FUNC_WAIT_ACK: push_entry.kind = CMD_WAIT_ACK;
            FUNC_READ:     push_entry.kind = CMD_READ;
            default:       push_entry.kind = CMD_NONE;
         endcase
      end
   end

endmodule

// ----- rtl/core/i2cmbs_queue.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer tick queue
// short fifo of classified ticks between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_macros.svh"

module i2cmbs_queue
   import i2cmbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tick_entry_type push_entry,
   output logic           q_ready,
   input  logic           pop,
   output logic           q_valid,
   output tick_entry_type q_entry
);

   tick_entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;

   // status
   assign q_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_entry = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `I2CMBS_ASSERT(a_queue_bound, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `I2CMBS_ASSERT(a_queue_pop_valid, !pop || q_valid, "pop from empty queue")
   `I2CMBS_ASSERT_NEXT(a_queue_grow, push && !pop, count_ff == $past(count_ff) + 1'b1, "fill lost")

endmodule

// ----- rtl/core/i2cmbs_back.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer back
// runs the bus phase sequencer one tick per queue entry, registers the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_macros.svh"

module i2cmbs_back
   import i2cmbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           q_valid,
   input  tick_entry_type q_entry,
   output logic           pop,
   i2cmbs_rsp_if.source   rsp_ch
);

   phase_type                phase_ff, phase_in;
   logic [BIT_COUNT_W-1:0]   bit_count_ff, bit_count_in;
   logic [7:0]               shift_ff, shift_in;
   logic [DELAY_W-1:0]       delay_ff, delay_in;
   logic [7:0]               ack_count_ff, ack_count_in;
   logic                     ack_choice_ff, ack_choice_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;
   logic                     timeout_ff, timeout_in;
   logic [7:0]               rx_hold_ff, rx_hold_in;
   logic                     done_in;

   logic                     rsp_valid_ff;
   logic                     rsp_scl_ff, rsp_scl_in;
   logic                     rsp_sda_ff, rsp_sda_in;
   logic                     rsp_busy_ff, rsp_busy_in;
   logic                     rsp_done_ff, rsp_done_in;
   logic [7:0]               rsp_rx_ff, rsp_rx_in;
   logic                     rsp_timeout_ff, rsp_timeout_in;

   logic [15:0]              unit;
   logic [7:0]               wr_shifted;
   logic [7:0]               rd_shifted;
   logic [BIT_COUNT_W-1:0]   bit_count_inc;

   // one tick per transfer whenever the result slot is free or draining
   assign pop = q_valid && (!rsp_valid_ff || rsp_ch.ready);

   // a zero unit behaves as one tick
   assign unit          = (cfg.ticks_per_unit == '0) ? 16'd1 : cfg.ticks_per_unit;
   assign wr_shifted    = {shift_ff[6:0], 1'b0};
   assign rd_shifted    = {shift_ff[6:0], q_entry.sda_sampled};
   assign bit_count_inc = bit_count_ff + 1'b1;

   // next state of the sequencer for this tick
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      delay_in      = delay_ff;
      ack_count_in  = ack_count_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      timeout_in    = timeout_ff;
      rx_hold_in    = rx_hold_ff;
      done_in       = 1'b0;

      priority if (phase_ff == PH_IDLE) begin
         // launch a new command
         if (q_entry.kind != CMD_NONE) begin
            bit_count_in = '0;
         end
         unique case (q_entry.kind)
            CMD_START: begin
               phase_in = PH_START_A;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               delay_in = delay_ticks(unit, SHIFT_FOUR_UNITS);
            end
            CMD_STOP: begin
               phase_in = PH_STOP_A;
               scl_in   = 1'b0;
               sda_in   = 1'b0;
               delay_in = delay_ticks(unit, SHIFT_FOUR_UNITS);
            end
            CMD_WRITE: begin
               shift_in = q_entry.tx_byte;
               phase_in = PH_WR_A;
               scl_in   = 1'b0;
               sda_in   = q_entry.tx_byte[7];
               delay_in = delay_ticks(unit, SHIFT_TWO_UNITS);
            end
            CMD_WAIT_ACK: begin
               timeout_in   = 1'b0;
               ack_count_in = '0;
               phase_in     = PH_WA_A;
               sda_in       = 1'b1;
               delay_in     = delay_ticks(unit, SHIFT_ONE_UNIT);
            end
            CMD_READ: begin
               ack_choice_in = q_entry.send_ack;
               shift_in      = '0;
               phase_in      = PH_RD_A;
               scl_in        = 1'b0;
               sda_in        = 1'b1;
               delay_in      = delay_ticks(unit, SHIFT_TWO_UNITS);
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end else if (phase_ff == PH_WA_POLL) begin
         // poll sda for the slave ack
         if (!q_entry.sda_sampled) begin
            scl_in   = 1'b0;
            phase_in = PH_IDLE;
            delay_in = '0;
            done_in  = 1'b1;
         end else begin
            if (ack_count_ff != ACK_COUNT_MAX) begin
               ack_count_in = ack_count_ff + 1'b1;
            end
            if (ack_count_ff >= cfg.ack_limit) begin
               timeout_in = 1'b1;
               phase_in   = PH_STOP_A;
               scl_in     = 1'b0;
               sda_in     = 1'b0;
               delay_in   = delay_ticks(unit, SHIFT_FOUR_UNITS);
            end
         end
      end else if (delay_ff > DELAY_W'(1)) begin
         // hold the current phase
         delay_in = delay_ff - 1'b1;
      end else if (phase_ff == PH_RD_B) begin
         // sample one read bit at the end of scl high
         shift_in     = rd_shifted;
         bit_count_in = bit_count_inc;
         scl_in       = 1'b0;
         delay_in     = delay_ticks(unit, SHIFT_TWO_UNITS);
         if (bit_count_inc >= BITS_PER_BYTE) begin
            phase_in = PH_AK_A;
            sda_in   = !ack_choice_ff;
         end else begin
            phase_in = PH_RD_A;
            sda_in   = 1'b1;
         end
      end else begin
         // phase delay expired, step to the next phase
         unique case (phase_ff)
            PH_START_A: begin
               phase_in = PH_START_B;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               delay_in = delay_ticks(unit, SHIFT_FOUR_UNITS);
            end
            PH_START_B: begin
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               delay_in = '0;
               done_in  = 1'b1;
            end
            PH_STOP_A: begin
               phase_in = PH_STOP_B;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               delay_in = delay_ticks(unit, SHIFT_FOUR_UNITS);
            end
            PH_STOP_B: begin
               phase_in = PH_STOP_C;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               delay_in = delay_ticks(unit, SHIFT_FOUR_UNITS);
            end
            PH_STOP_C: begin
               phase_in = PH_IDLE;
               delay_in = '0;
               done_in  = 1'b1;
            end
            PH_WR_A: begin
               phase_in = PH_WR_B;
               scl_in   = 1'b1;
               delay_in = delay_ticks(unit, SHIFT_TWO_UNITS);
            end
            PH_WR_B: begin
               phase_in = PH_WR_C;
               scl_in   = 1'b0;
               delay_in = delay_ticks(unit, SHIFT_TWO_UNITS);
            end
            PH_WR_C: begin
               shift_in     = wr_shifted;
               bit_count_in = bit_count_inc;
               if (bit_count_inc >= BITS_PER_BYTE) begin
                  phase_in = PH_IDLE;
                  delay_in = '0;
                  done_in  = 1'b1;
               end else begin
                  phase_in = PH_WR_A;
                  scl_in   = 1'b0;
                  sda_in   = wr_shifted[7];
                  delay_in = delay_ticks(unit, SHIFT_TWO_UNITS);
               end
            end
            PH_WA_A: begin
               phase_in = PH_WA_B;
               scl_in   = 1'b1;
               delay_in = delay_ticks(unit, SHIFT_ONE_UNIT);
            end
            PH_WA_B: begin
               phase_in = PH_WA_POLL;
               delay_in = '0;
            end
            PH_RD_A: begin
               phase_in = PH_RD_B;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               delay_in = delay_ticks(unit, SHIFT_TWO_UNITS);
            end
            PH_AK_A: begin
               phase_in = PH_AK_B;
               scl_in   = 1'b1;
               delay_in = delay_ticks(unit, SHIFT_TWO_UNITS);
            end
            PH_AK_B: begin
               scl_in     = 1'b0;
               rx_hold_in = shift_ff;
               phase_in   = PH_IDLE;
               delay_in   = '0;
               done_in    = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // result fields as seen after the tick
   always_comb begin
      rsp_scl_in     = scl_in;
      rsp_sda_in     = sda_in;
      rsp_busy_in    = phase_in != PH_IDLE;
      rsp_done_in    = done_in;
      rsp_rx_in      = rx_hold_in;
      rsp_timeout_in = timeout_in;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         delay_ff      <= '0;
         ack_count_ff  <= '0;
         ack_choice_ff <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         timeout_ff    <= 1'b0;
         rx_hold_ff    <= '0;
      end else if (pop) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         delay_ff      <= delay_in;
         ack_count_ff  <= ack_count_in;
         ack_choice_ff <= ack_choice_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         timeout_ff    <= timeout_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   // result slot valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result slot payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_scl_ff     <= rsp_scl_in;
         rsp_sda_ff     <= rsp_sda_in;
         rsp_busy_ff    <= rsp_busy_in;
         rsp_done_ff    <= rsp_done_in;
         rsp_rx_ff      <= rsp_rx_in;
         rsp_timeout_ff <= rsp_timeout_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scl_release  = rsp_scl_ff;
   assign rsp_ch.sda_release  = rsp_sda_ff;
   assign rsp_ch.busy_res     = rsp_busy_ff;
   assign rsp_ch.cmd_done     = rsp_done_ff;
   assign rsp_ch.rx_byte      = rsp_rx_ff;
   assign rsp_ch.nack_timeout = rsp_timeout_ff;

   `I2CMBS_ASSERT(a_idle_no_delay, phase_ff != PH_IDLE || delay_ff == '0, "idle delay")
   `I2CMBS_ASSERT(a_bit_count_range, bit_count_ff <= BITS_PER_BYTE, "bit count past one byte")
   `I2CMBS_ASSERT(a_done_not_busy, !(rsp_valid_ff && rsp_done_ff && rsp_busy_ff), "done and busy")

endmodule

// ----- rtl/core/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer top level
// Usage: every transfer on req_ch is one time tick of the bus sequencer. It
// carries an optional command (start, stop, write byte, wait ack, read byte)
// and the sampled sda level. For each tick exactly one result leaves on rsp_ch
// with the open-drain scl/sda release levels, busy, command done, the last
// read byte and the ack timeout flag. csr_ch writes register 0 (ticks per
// delay unit) and register 1 (ack timeout limit); it is always ready and
// writes to other indexes are dropped. Write it only while the block is idle.
// Path: a tick is registered in the queue, then its result in the result slot.
// Throughput: one tick per cycle while rsp_ch is not stalled, set by the phase
// step of the back sequencer fed from a two-entry tick queue.
// Reset: synchronous; lines released, sequencer idle, registers at 1 and 250,
// queue and result slot empty.
// Stall: a stalled rsp_ch holds its result; the queue absorbs up to two more
// ticks, then req_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_sequencer
   import i2cmbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   i2cmbs_req_if.sink    req_ch,
   i2cmbs_rsp_if.source  rsp_ch,
   i2cmbs_csr_if.sink    csr_ch
);

   logic [15:0]    ticks_per_unit_ff;
   logic [7:0]     ack_limit_ff;
   cfg_type        cfg;
   logic           push;
   tick_entry_type push_entry;
   logic           q_ready;
   logic           q_valid;
   tick_entry_type q_entry;
   logic           pop;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_unit_ff <= TICKS_PER_UNIT_RESET;
         ack_limit_ff      <= ACK_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.addr == CSR_TICKS_PER_UNIT) begin
            ticks_per_unit_ff <= csr_ch.wdata;
         end
         if (csr_ch.addr == CSR_ACK_LIMIT) begin
            ack_limit_ff <= csr_ch.wdata[7:0];
         end
      end
   end

   assign cfg.ticks_per_unit = ticks_per_unit_ff;
   assign cfg.ack_limit      = ack_limit_ff;

   // request front
   i2cmbs_front u_front (
      .req_ch     (req_ch),
      .q_ready    (q_ready),
      .push       (push),
      .push_entry (push_entry)
   );

   // tick queue
   i2cmbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_ready    (q_ready),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   // phase sequencer and result slot
   i2cmbs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ----- dv/i2c_master_bit_sequencer_checker.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer checker
// Watches the request, response and csr channels. Every request transfer is
// stepped through a bus-phase predictor, and the predicted line levels and
// status are queued. Every response transfer is compared field by field with
// the oldest queued prediction. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_checker
   import i2cmbs_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   i2cmbs_req_if  req_ch,
   i2cmbs_rsp_if  rsp_ch,
   i2cmbs_csr_if  csr_ch,
   output int     error_count,
   output int     pending_count,
   output logic   line_busy
);

   // line levels and status after one tick
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       timeout;
   } bus_result_type;

   // register copies
   logic [15:0]        unit_ticks;
   logic [7:0]         ack_limit;

   // sequencer state
   phase_type          seq_phase;
   logic [3:0]         bits_done;
   logic [7:0]         shift_reg;
   logic [DELAY_W-1:0] delay_left;
   logic [7:0]         ack_polls;
   logic               ack_sel;
   logic               scl_lvl;
   logic               sda_lvl;
   logic               timeout_seen;
   logic [7:0]         rx_hold;
   logic               cmd_finished;

   bus_result_type     pending_levels[$];

   // set both lines and load the hold time of a phase
   task automatic enter_phase(input phase_type nxt, input logic scl, input logic sda,
                              input int units);
      logic [DELAY_W-1:0] one_unit;
      one_unit = DELAY_W'(unit_ticks);
      if (one_unit == '0) one_unit = DELAY_W'(1);
      seq_phase  = nxt;
      scl_lvl    = scl;
      sda_lvl    = sda;
      delay_left = DELAY_W'(one_unit * units);
   endtask

   task automatic finish_cmd();
      seq_phase    = PH_IDLE;
      delay_left   = '0;
      cmd_finished = 1'b1;
   endtask

   // one tick of the bus sequencer
   task automatic step_bus_tick(input logic cv, input logic [2:0] fn, input logic [7:0] tx,
                                input logic sa, input logic sd);
      logic [7:0] prev_polls;
      cmd_finished = 1'b0;
      if (seq_phase == PH_IDLE) begin
         // commands are taken only while idle, unknown codes dropped
         if (cv && fn <= FUNC_READ) begin
            bits_done = '0;
            case (fn)
               FUNC_START: enter_phase(PH_START_A, 1'b1, 1'b1, 4);
               FUNC_STOP:  enter_phase(PH_STOP_A, 1'b0, 1'b0, 4);
               FUNC_WRITE: begin
                  shift_reg = tx;
                  enter_phase(PH_WR_A, 1'b0, tx[7], 2);
               end
               FUNC_WAIT_ACK: begin
                  timeout_seen = 1'b0;
                  ack_polls    = '0;
                  enter_phase(PH_WA_A, scl_lvl, 1'b1, 1);
               end
               default: begin
                  ack_sel   = sa;
                  shift_reg = '0;
                  enter_phase(PH_RD_A, 1'b0, 1'b1, 2);
               end
            endcase
         end
      end else if (seq_phase == PH_WA_POLL) begin
         // poll sda, low completes, too many highs turn into a stop
         if (!sd) begin
            scl_lvl = 1'b0;
            finish_cmd();
         end else begin
            prev_polls = ack_polls;
            if (ack_polls != ACK_COUNT_MAX) ack_polls = ack_polls + 1'b1;
            if (prev_polls >= ack_limit) begin
               timeout_seen = 1'b1;
               enter_phase(PH_STOP_A, 1'b0, 1'b0, 4);
            end
         end
      end else if (delay_left > 1) begin
         delay_left = delay_left - 1'b1;
      end else if (seq_phase == PH_RD_B) begin
         // last tick of scl high: shift in the sampled bit
         shift_reg = {shift_reg[6:0], sd};
         bits_done = bits_done + 1'b1;
         if (bits_done >= BITS_PER_BYTE) enter_phase(PH_AK_A, 1'b0, !ack_sel, 2);
         else enter_phase(PH_RD_A, 1'b0, 1'b1, 2);
      end else begin
         // hold time over: move to the next phase
         case (seq_phase)
            PH_START_A: enter_phase(PH_START_B, 1'b1, 1'b0, 4);
            PH_START_B: begin
               scl_lvl = 1'b0;
               finish_cmd();
            end
            PH_STOP_A:  enter_phase(PH_STOP_B, 1'b1, 1'b0, 4);
            PH_STOP_B:  enter_phase(PH_STOP_C, 1'b1, 1'b1, 4);
            PH_STOP_C:  finish_cmd();
            PH_WR_A:    enter_phase(PH_WR_B, 1'b1, sda_lvl, 2);
            PH_WR_B:    enter_phase(PH_WR_C, 1'b0, sda_lvl, 2);
            PH_WR_C: begin
               shift_reg = {shift_reg[6:0], 1'b0};
               bits_done = bits_done + 1'b1;
               if (bits_done >= BITS_PER_BYTE) finish_cmd();
               else enter_phase(PH_WR_A, 1'b0, shift_reg[7], 2);
            end
            PH_WA_A:    enter_phase(PH_WA_B, 1'b1, sda_lvl, 1);
            PH_WA_B: begin
               seq_phase  = PH_WA_POLL;
               delay_left = '0;
            end
            PH_RD_A:    enter_phase(PH_RD_B, 1'b1, 1'b1, 2);
            PH_AK_A:    enter_phase(PH_AK_B, 1'b1, sda_lvl, 2);
            PH_AK_B: begin
               scl_lvl = 1'b0;
               rx_hold = shift_reg;
               finish_cmd();
            end
            default:    seq_phase = PH_IDLE;
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: rsp %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      bus_result_type want;
      if (reset) begin
         unit_ticks   = TICKS_PER_UNIT_RESET;
         ack_limit    = ACK_LIMIT_RESET;
         seq_phase    = PH_IDLE;
         bits_done    = '0;
         shift_reg    = '0;
         delay_left   = '0;
         ack_polls    = '0;
         ack_sel      = 1'b0;
         scl_lvl      = 1'b1;
         sda_lvl      = 1'b1;
         timeout_seen = 1'b0;
         rx_hold      = '0;
         cmd_finished = 1'b0;
         pending_levels.delete();
      end else begin
         // response transfer against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_levels.size() == 0) begin
               error_count++;
               $display("%0t: rsp transfer unexpected, expected none actual scl %0h sda %0h",
                        $time, rsp_ch.scl_release, rsp_ch.sda_release);
            end else begin
               want = pending_levels.pop_front();
               check_field("scl_release", want.scl, rsp_ch.scl_release);
               check_field("sda_release", want.sda, rsp_ch.sda_release);
               check_field("busy_res", want.busy, rsp_ch.busy_res);
               check_field("cmd_done", want.done, rsp_ch.cmd_done);
               check_field("rx_byte", want.rx, rsp_ch.rx_byte);
               check_field("nack_timeout", want.timeout, rsp_ch.nack_timeout);
            end
         end
         // register write, other indexes dropped
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.addr == CSR_TICKS_PER_UNIT) unit_ticks = csr_ch.wdata;
            else if (csr_ch.addr == CSR_ACK_LIMIT) ack_limit = csr_ch.wdata[7:0];
         end
         // request transfer: one tick
         if (req_ch.valid && req_ch.ready) begin
            step_bus_tick(req_ch.cmd_valid, req_ch.func, req_ch.tx_byte, req_ch.send_ack,
                          req_ch.sda_sampled);
            want.scl     = scl_lvl;
            want.sda     = sda_lvl;
            want.busy    = (seq_phase != PH_IDLE);
            want.done    = cmd_finished;
            want.rx      = rx_hold;
            want.timeout = timeout_seen;
            pending_levels.push_back(want);
         end
      end
      pending_count = pending_levels.size();
      line_busy     = (seq_phase != PH_IDLE);
   end

endmodule

// ----- dv/i2c_master_bit_sequencer_test.sv -----
// ----------------------------------------------------------------------------
// i2c master bit sequencer testbench
// Drives bus ticks with commands (start, stop, write, wait ack, read) and
// stray command codes under several register settings, from the reset values
// through a zero unit and ack limits 0 and 255. A directed part covers the
// edge cases, then random i2c transactions with noise follow. The sender
// idles in bursts and the receiver stalls; the checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_test;
   import i2cmbs_pkg::*;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int PHASE_TICKS   = 160;
   localparam int RANDOM_PHASES = 3;

   // command codes the block ignores
   localparam logic [2:0] FUNC_RSVD_LO  = 3'd5;
   localparam logic [2:0] FUNC_RSVD_MID = 3'd6;
   localparam logic [2:0] FUNC_RSVD_HI  = 3'd7;

   // register indexes outside the map
   localparam logic [7:0] CSR_UNUSED_LOW = 8'd2;
   localparam logic [7:0] CSR_UNUSED_TOP = 8'hFF;

   logic        clock;
   logic        reset;
   int          error_count;
   int          pending_count;
   logic        line_busy;
   int          cycle_count = 0;
   int          ticks_sent  = 0;
   int          burst_left;
   bit          gaps_on;
   int          eff_unit;
   logic [7:0]  cur_limit;
   int          stall_mode;
   int          stall_left;
   int          phase_idx;
   int          target;

   i2cmbs_req_if req_ch();
   i2cmbs_rsp_if rsp_ch();
   i2cmbs_csr_if csr_ch();

   i2c_master_bit_sequencer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   i2c_master_bit_sequencer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .error_count   (error_count),
      .pending_count (pending_count),
      .line_busy     (line_busy)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("i2c_master_bit_sequencer test failed");
         $finish;
      end
   end

   // receiver stalls in stretches of changing pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode   <= 0;
         stall_left   <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 160);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= $urandom_range(0, 1);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= stall_left[4];
         endcase
      end
   end

   // one tick transfer, with idle gaps between bursts
   task automatic send_tick(input logic cv, input logic [2:0] fn, input logic [7:0] tx,
                            input logic sa, input logic sd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd_valid   <= cv;
      req_ch.func        <= fn;
      req_ch.tx_byte     <= tx;
      req_ch.send_ack    <= sa;
      req_ch.sda_sampled <= sd;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      ticks_sent++;
   endtask

   // wait for all responses, tick on until the sequencer is idle
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      while (line_busy) begin
         @(posedge clock);
         repeat (32) send_tick(1'b0, FUNC_START, 8'h00, 1'b0, 1'b0);
         req_ch.valid <= 1'b0;
         do @(negedge clock); while (pending_count != 0);
      end
      @(posedge clock);
   endtask

   // register writes while idle, optionally with stray indexes
   task automatic configure(input logic [15:0] unit, input logic [7:0] limit, input bit stray);
      logic [7:0]  idx[4];
      logic [15:0] val[4];
      int          n;
      int          k;
      idx[0] = CSR_TICKS_PER_UNIT;
      val[0] = unit;
      idx[1] = CSR_ACK_LIMIT;
      val[1] = {8'($urandom_range(0, 255)), limit};
      idx[2] = CSR_UNUSED_LOW;
      val[2] = $urandom_range(0, 65535);
      idx[3] = CSR_UNUSED_TOP;
      val[3] = $urandom_range(0, 65535);
      n = stray ? 4 : 2;
      for (k = 0; k < n; k++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.addr  <= idx[k];
         csr_ch.wdata <= val[k];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
      cur_limit = limit;
      eff_unit  = (unit == 0) ? 1 : unit;
   endtask

   // one command and the ticks it runs for, with noise when jittered
   task automatic run_command(input logic [2:0] fn, input logic [7:0] tx, input logic sa,
                              input bit never_ack, input bit jitter);
      int         span;
      int         ack_at;
      int         k;
      logic       sd;
      logic [2:0] nf;
      logic [7:0] nt;
      logic       ns;
      ack_at = 0;
      case (fn)
         FUNC_START:    span = 8 * eff_unit;
         FUNC_STOP:     span = 12 * eff_unit;
         FUNC_WRITE:    span = 48 * eff_unit;
         FUNC_READ:     span = 40 * eff_unit;
         FUNC_WAIT_ACK: begin
            if (never_ack) begin
               span = 14 * eff_unit + cur_limit + 2;
            end else begin
               ack_at = 2 * eff_unit + $urandom_range(0, (cur_limit < 6) ? cur_limit : 6);
               span   = ack_at + 1;
            end
         end
         default:       span = 0;
      endcase
      span += $urandom_range(1, 3);
      // sometimes cut short so the next command lands while busy
      if (jitter && $urandom_range(0, 9) == 0) span = $urandom_range(0, span / 2);
      sd = (fn == FUNC_WAIT_ACK) ? 1'b1 : 1'($urandom_range(0, 1));
      send_tick(1'b1, fn, tx, sa, sd);
      for (k = 0; k < span; k++) begin
         if (fn == FUNC_WAIT_ACK) sd = (never_ack || k < ack_at);
         else sd = $urandom_range(0, 1);
         if (jitter && $urandom_range(0, 5) == 0) begin
            nf = $urandom_range(0, 7);
            nt = $urandom_range(0, 255);
            ns = $urandom_range(0, 1);
            send_tick(1'b1, nf, nt, ns, sd);
         end else begin
            send_tick(1'b0, fn, tx, sa, sd);
         end
      end
   endtask

   // start, address byte, ack, a few data bytes, stop
   task automatic run_transaction();
      int n;
      bit never_ack;
      never_ack = (cur_limit <= 16) && ($urandom_range(0, 2) == 0);
      run_command(FUNC_START, 8'h00, 1'b0, 1'b0, 1'b1);
      run_command(FUNC_WRITE, $urandom_range(0, 255), 1'b0, 1'b0, 1'b1);
      run_command(FUNC_WAIT_ACK, 8'h00, 1'b0, never_ack, 1'b1);
      n = $urandom_range(0, 3);
      repeat (n) begin
         if ($urandom_range(0, 1)) begin
            run_command(FUNC_WRITE, $urandom_range(0, 255), 1'b0, 1'b0, 1'b1);
            run_command(FUNC_WAIT_ACK, 8'h00, 1'b0,
                        (cur_limit <= 16) && ($urandom_range(0, 4) == 0), 1'b1);
         end else begin
            run_command(FUNC_READ, 8'h00, $urandom_range(0, 1), 1'b0, 1'b1);
         end
      end
      run_command(FUNC_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.cmd_valid   = 1'b0;
      req_ch.func        = FUNC_START;
      req_ch.tx_byte     = 8'h00;
      req_ch.send_ack    = 1'b0;
      req_ch.sda_sampled = 1'b1;
      csr_ch.valid       = 1'b0;
      csr_ch.addr        = CSR_TICKS_PER_UNIT;
      csr_ch.wdata       = '0;
      rsp_ch.ready       = 1'b0;
      burst_left         = 0;
      gaps_on            = 1'b1;
      cur_limit          = ACK_LIMIT_RESET;
      eff_unit           = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      run_command(FUNC_START, 8'h00, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_WAIT_ACK, 8'h00, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_WRITE, 8'h00, 1'b1, 1'b0, 1'b0);
      run_command(FUNC_WAIT_ACK, 8'hFF, 1'b1, 1'b0, 1'b0);
      run_command(FUNC_READ, 8'hFF, 1'b1, 1'b0, 1'b0);
      run_command(FUNC_READ, 8'h00, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_RSVD_LO, 8'hFF, 1'b1, 1'b0, 1'b0);
      run_command(FUNC_RSVD_MID, 8'h00, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_RSVD_HI, 8'hAA, 1'b1, 1'b0, 1'b0);
      // no command offered, then a command while busy
      send_tick(1'b0, FUNC_STOP, 8'h55, 1'b1, 1'b0);
      send_tick(1'b0, FUNC_WRITE, 8'hAA, 1'b0, 1'b1);
      send_tick(1'b1, FUNC_START, 8'h00, 1'b0, 1'b1);
      send_tick(1'b1, FUNC_WRITE, 8'hA5, 1'b0, 1'b1);
      send_tick(1'b1, FUNC_WAIT_ACK, 8'h5A, 1'b1, 1'b0);
      drain();

      // zero delay unit, ack limit 0, stray register indexes
      configure(16'd0, 8'd0, 1'b1);
      run_command(FUNC_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b0);
      run_command(FUNC_WAIT_ACK, 8'h00, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_START, 8'h00, 1'b0, 1'b0, 1'b0);
      run_command(FUNC_READ, 8'h00, 1'b1, 1'b0, 1'b0);
      drain();

      // largest ack limit: poll count saturates before the timeout
      configure(16'd1, 8'd255, 1'b0);
      run_command(FUNC_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b0);
      run_command(FUNC_WRITE, 8'h5A, 1'b0, 1'b0, 1'b0);
      drain();

      // random transactions under varying settings
      for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         case ($urandom_range(0, 3))
            0:       configure(16'd1, $urandom_range(0, 3), 1'b0);
            1:       configure($urandom_range(1, 4), $urandom_range(0, 16), 1'b0);
            2:       configure(16'd2, $urandom_range(0, 255), $urandom_range(0, 1));
            default: configure($urandom_range(0, 3), $urandom_range(1, 8), 1'b0);
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         target  = ticks_sent + PHASE_TICKS;
         while (ticks_sent < target) begin
            if ($urandom_range(0, 4) == 0)
               run_command($urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 1),
                           (cur_limit <= 16) && $urandom_range(0, 1), 1'b1);
            else
               run_transaction();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("i2c_master_bit_sequencer test passed");
      else
         $display("i2c_master_bit_sequencer test failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/i2cmbs_pkg.sv
rtl/core/i2cmbs_ifs.sv
rtl/core/i2cmbs_front.sv
rtl/core/i2cmbs_queue.sv
rtl/core/i2cmbs_back.sv
rtl/core/i2c_master_bit_sequencer.sv
dv/i2c_master_bit_sequencer_checker.sv
dv/i2c_master_bit_sequencer_test.sv
